>>> rtl/perspective_rotate_coordinate_map_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the perspective rotate coordinate map
// Implication checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_ROTATE_COORDINATE_MAP_TOP_ASSERT_SVH
`define PERSPECTIVE_ROTATE_COORDINATE_MAP_TOP_ASSERT_SVH
`ifndef SYNTH
`define PRCM_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define PRCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PRCM_ASSERT_SAME(label, clk, rst_n, pre, post)
`define PRCM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/prcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Package for the perspective rotate coordinate map
// Types, register codes and saturation helpers shared by all modules.
// ----------------------------------------------------------------------------
package prcm_pkg;

  localparam int DX_W      = 12;
  localparam int GAIN_FRAC = 28;
  localparam int QW        = 33;
  localparam int NREG      = 7;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_GAIN_W   = 3'd2,
    REG_BIAS_XY  = 3'd3,
    REG_BIAS_WS  = 3'd4,
    REG_OFFSET   = 3'd5,
    REG_ORIGIN   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] gain_x;
    logic [63:0] gain_y;
    logic [63:0] gain_w;
    logic [63:0] bias_xy;
    logic [63:0] bias_ws;
    logic [63:0] offset_xy;
    logic [63:0] origin_xy;
  } cfg_t;

  typedef struct packed {
    logic [QW-1:0]       dvd;
    logic [31:0]         rem;
    logic [QW-1:0]       quo;
    logic                neg;
    logic                ovf;
    logic                pnn;
    logic signed [31:0]  off;
  } lane_t;

  typedef struct packed {
    logic [31:0] dmag;
    logic        dzero;
    lane_t       lx;
    lane_t       ly;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] lane_result(input lane_t l, input logic dzero);
    logic signed [QW:0] qs;
    logic signed [31:0] r;
    qs = l.neg ? -$signed({1'b0, l.quo}) : $signed({1'b0, l.quo});
    if (dzero) begin
      r = l.pnn ? S32_MAX : S32_MIN;
    end else if (l.ovf) begin
      r = l.neg ? S32_MIN : S32_MAX;
    end else begin
      r = sat32(64'(qs) + 64'(l.off));
    end
    return r;
  endfunction

endpackage

>>> rtl/prcm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel offset request channel
// Valid/ready channel carrying one destination pixel offset.
// ----------------------------------------------------------------------------
interface prcm_in_if;
  logic                       valid;
  logic                       ready;
  logic [prcm_pkg::DX_W-1:0]  dst_dx;
  logic [prcm_pkg::DX_W-1:0]  dst_dy;

  modport source (output valid, output dst_dx, output dst_dy, input ready);
  modport sink (input valid, input dst_dx, input dst_dy, output ready);
endinterface

>>> rtl/prcm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source coordinate result channel
// Valid/ready channel carrying one mapped source coordinate.
// ----------------------------------------------------------------------------
interface prcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic               denom_zero;

  modport source (output valid, output src_x, output src_y, output denom_zero, input ready);
  modport sink (input valid, input src_x, input src_y, input denom_zero, output ready);
endinterface

>>> rtl/prcm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write and read access to the seven 64-bit mapping registers.
// ----------------------------------------------------------------------------
module prcm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prcm_pkg::ADDR_W-1:0]   paddr,
  input  logic [prcm_pkg::DATA_W-1:0]   pwdata,
  output logic [prcm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output prcm_pkg::cfg_t                cfg_o
);
  import prcm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  reg_idx_e   idx;
  logic       wr;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (idx)
      REG_GAIN_X: begin
        prdata = cfg_q.gain_x;
        if (wr) cfg_d.gain_x = pwdata;
      end
      REG_GAIN_Y: begin
        prdata = cfg_q.gain_y;
        if (wr) cfg_d.gain_y = pwdata;
      end
      REG_GAIN_W: begin
        prdata = cfg_q.gain_w;
        if (wr) cfg_d.gain_w = pwdata;
      end
      REG_BIAS_XY: begin
        prdata = cfg_q.bias_xy;
        if (wr) cfg_d.bias_xy = pwdata;
      end
      REG_BIAS_WS: begin
        prdata = cfg_q.bias_ws;
        if (wr) cfg_d.bias_ws = pwdata;
      end
      REG_OFFSET: begin
        prdata = cfg_q.offset_xy;
        if (wr) cfg_d.offset_xy = pwdata;
      end
      REG_ORIGIN: begin
        prdata = cfg_q.origin_xy;
        if (wr) cfg_d.origin_xy = pwdata;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/prcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection front end
// Forms X and Y, the three dot products and the numerator products, then
// sets up the magnitudes that enter the divider cell row.
// ----------------------------------------------------------------------------
module prcm_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [prcm_pkg::DX_W-1:0]   dx_i,
  input  logic [prcm_pkg::DX_W-1:0]   dy_i,
  input  prcm_pkg::cfg_t              cfg_i,
  output logic                        valid_o,
  output prcm_pkg::div_t              d_o
);
  import prcm_pkg::*;

  localparam int USE_W = (COORD_BITS < DX_W) ? COORD_BITS : DX_W;
  localparam int RAW_W = COORD_BITS + FRAC_BITS + 2;
  localparam int SUM_W = (RAW_W > 34) ? RAW_W : 34;

  logic [5:0] vld_q;

  logic [USE_W-1:0]          dx_q, dy_q;
  logic signed [SUM_W-1:0]   dxs, dys, xs, ys;
  logic signed [31:0]        x_q, y_q;
  logic signed [63:0]        pwx_q, pwy_q, pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [31:0]        den_d, nx_d, ny_d;
  logic signed [31:0]        den_q, nx_q, ny_q;
  logic signed [63:0]        px_q, py_q;
  logic signed [31:0]        den4_q;
  div_t                      d_d, d_q;

  function automatic logic signed [31:0] dot3(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input logic signed [31:0] bias);
    logic signed [63:0] s;
    s = (a >>> GAIN_FRAC) + (b >>> GAIN_FRAC) + 64'(bias);
    return sat32(s);
  endfunction

  function automatic lane_t lane_init(input logic signed [63:0] p,
                                      input logic [31:0] dm,
                                      input logic dneg,
                                      input logic signed [31:0] off);
    lane_t l;
    logic [63:0] pm;
    pm    = p[63] ? 64'(-p) : 64'(p);
    l.rem = 32'(pm[62:QW]);
    l.dvd = pm[QW-1:0];
    l.quo = '0;
    l.ovf = (32'(pm[62:QW]) >= dm);
    l.neg = p[63] ^ dneg;
    l.pnn = ~p[63];
    l.off = off;
    return l;
  endfunction

  assign dxs = $signed(SUM_W'(dx_q) << FRAC_BITS);
  assign dys = $signed(SUM_W'(dy_q) << FRAC_BITS);
  assign xs  = SUM_W'($signed(cfg_i.origin_xy[31:0])) + dxs;
  assign ys  = SUM_W'($signed(cfg_i.origin_xy[63:32])) + dys;

  assign den_d = dot3(pwx_q, pwy_q, $signed(cfg_i.bias_ws[31:0]));
  assign nx_d  = dot3(pxx_q, pxy_q, $signed(cfg_i.bias_xy[31:0]));
  assign ny_d  = dot3(pyx_q, pyy_q, $signed(cfg_i.bias_xy[63:32]));

  always_comb begin
    d_d.dmag  = den4_q[31] ? 32'(-den4_q) : 32'(den4_q);
    d_d.dzero = (den4_q == '0);
    d_d.lx    = lane_init(px_q, d_d.dmag, den4_q[31], $signed(cfg_i.offset_xy[31:0]));
    d_d.ly    = lane_init(py_q, d_d.dmag, den4_q[31], $signed(cfg_i.offset_xy[63:32]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_i[USE_W-1:0];
      dy_q   <= dy_i[USE_W-1:0];
      x_q    <= sat32(64'(xs));
      y_q    <= sat32(64'(ys));
      pwx_q  <= $signed(cfg_i.gain_w[31:0])  * x_q;
      pwy_q  <= $signed(cfg_i.gain_w[63:32]) * y_q;
      pxx_q  <= $signed(cfg_i.gain_x[31:0])  * x_q;
      pxy_q  <= $signed(cfg_i.gain_x[63:32]) * y_q;
      pyx_q  <= $signed(cfg_i.gain_y[31:0])  * x_q;
      pyy_q  <= $signed(cfg_i.gain_y[63:32]) * y_q;
      den_q  <= den_d;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      px_q   <= nx_q * $signed(cfg_i.bias_ws[63:32]);
      py_q   <= ny_q * $signed(cfg_i.bias_ws[63:32]);
      den4_q <= den_q;
      d_q    <= d_d;
    end
  end

  assign valid_o = vld_q[5];
  assign d_o     = d_q;

endmodule

>>> rtl/prcm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit for both lanes and passes the request on.
// ----------------------------------------------------------------------------
module prcm_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  prcm_pkg::div_t  d_i,
  output logic            valid_o,
  output prcm_pkg::div_t  d_o
);
  import prcm_pkg::*;

  logic  valid_q;
  div_t  d_d, d_q;

  function automatic lane_t lane_step(input lane_t l, input logic [31:0] dm);
    lane_t r;
    logic [32:0] t;
    logic        ge;
    r   = l;
    t   = {l.rem, l.dvd[QW-1]};
    ge  = (t >= {1'b0, dm});
    r.rem = ge ? 32'(t - {1'b0, dm}) : t[31:0];
    r.dvd = {l.dvd[QW-2:0], 1'b0};
    r.quo = {l.quo[QW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    d_d    = d_i;
    d_d.lx = lane_step(d_i.lx, d_i.dmag);
    d_d.ly = lane_step(d_i.ly, d_i.dmag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

>>> rtl/perspective_rotate_coordinate_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Perspective rotate coordinate map
// Maps a destination pixel offset to its projective source coordinate.
// ----------------------------------------------------------------------------
//  channel    direction  carries
//  in_req_i   in         dst_dx, dst_dy
//  out_res_o  out        src_x, src_y, denom_zero
//  apb        in/out     seven 64-bit registers at byte address 8*i
//
// One request is taken every cycle while ready is high; it passes an input
// register, five front-end stages, 33 divider cells at one quotient bit each,
// and the output register. Reset clears all pipeline valid bits and the
// registers. The row advances whenever its last cell is empty or the output
// register can take a request, so bubbles close up while a result waits.
module perspective_rotate_coordinate_map_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prcm_in_if.sink                       in_req_i,
  prcm_out_if.source                    out_res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prcm_pkg::ADDR_W-1:0]   paddr,
  input  logic [prcm_pkg::DATA_W-1:0]   pwdata,
  output logic [prcm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import prcm_pkg::*;

  `include "perspective_rotate_coordinate_map_top_assert.svh"

  cfg_t  cfg;
  logic  en, out_free;
  logic  vld [QW+1];
  div_t  dat [QW+1];

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] src_x_q, src_y_q;
  logic               dz_q;

  prcm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prcm_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_req_i.valid),
    .dx_i    (in_req_i.dst_dx),
    .dy_i    (in_req_i.dst_dy),
    .cfg_i   (cfg),
    .valid_o (vld[0]),
    .d_o     (dat[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    prcm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .d_i     (dat[i]),
      .valid_o (vld[i+1]),
      .d_o     (dat[i+1])
    );
  end

  assign out_free       = ~out_valid_q | out_res_o.ready;
  assign en             = ~vld[QW] | out_free;
  assign in_req_i.ready = en;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = vld[QW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      src_x_q <= lane_result(dat[QW].lx, dat[QW].dzero);
      src_y_q <= lane_result(dat[QW].ly, dat[QW].dzero);
      dz_q    <= dat[QW].dzero;
    end
  end

  assign out_res_o.valid      = out_valid_q;
  assign out_res_o.src_x      = src_x_q;
  assign out_res_o.src_y      = src_y_q;
  assign out_res_o.denom_zero = dz_q;

  `PRCM_ASSERT_SAME(a_dz_sat, clk_i, rst_ni, out_valid_q && dz_q,
    (src_x_q == S32_MAX || src_x_q == S32_MIN))
  `PRCM_ASSERT_SAME(a_ready_free, clk_i, rst_ni, !vld[QW], in_req_i.ready)
  `PRCM_ASSERT_NEXT(a_hold_last, clk_i, rst_ni,
    vld[QW] && out_valid_q && !out_res_o.ready, vld[QW] && out_valid_q)

endmodule
